### rtl/core/xte_pkg.sv
// Package for the XML text escaper: widths, character codes, register
// indexes and the escaped-run type. No dependencies.
package xte_pkg;

  localparam int BYTE_W    = 8;
  localparam int RUN_MAX   = 6;
  localparam int RUN_IDX_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_APOS_ENTITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_HEX    = 1'b1;

  localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3c;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3e;
  localparam logic [BYTE_W-1:0] CH_QUOT  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_3     = 8'h33;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_G     = 8'h67;
  localparam logic [BYTE_W-1:0] CH_L     = 8'h6c;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6d;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h6f;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h70;
  localparam logic [BYTE_W-1:0] CH_Q     = 8'h71;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
    logic [RUN_IDX_W-1:0]           last_idx;
  } xte_run_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + ext;
    end else begin
      return 8'h37 + ext;
    end
  endfunction

endpackage

### rtl/core/xte_if.sv
// Stream interfaces for the input and result words of the XML text escaper.
// Depends on xte_pkg for the byte width.
interface xte_in_if;
  logic                       valid;
  logic                       ready;
  logic [xte_pkg::BYTE_W-1:0] in_byte;
  logic                       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface xte_out_if;
  logic                       valid;
  logic                       ready;
  logic [xte_pkg::BYTE_W-1:0] out_byte;
  logic                       last_of_run;
  logic                       text_done;

  modport source (output valid, output out_byte, output last_of_run, output text_done,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input text_done,
                output ready);
endinterface

### rtl/core/xte_encode.sv
// Combinational encoder: maps one text byte to its escaped run of one to
// six bytes. Depends on xte_pkg.
module xte_encode (
  input  logic [xte_pkg::BYTE_W-1:0] c,
  input  logic                       apos_entity,
  input  logic                       ctrl_hex,
  output xte_pkg::xte_run_t          run
);
  import xte_pkg::*;

  always_comb begin
    run = '0;
    case (c)
      CH_AMP: begin
        run.bytes[0] = CH_AMP;
        run.bytes[1] = CH_A;
        run.bytes[2] = CH_M;
        run.bytes[3] = CH_P;
        run.bytes[4] = CH_SEMI;
        run.last_idx = 3'd4;
      end
      CH_LT: begin
        run.bytes[0] = CH_AMP;
        run.bytes[1] = CH_L;
        run.bytes[2] = CH_T;
        run.bytes[3] = CH_SEMI;
        run.last_idx = 3'd3;
      end
      CH_GT: begin
        run.bytes[0] = CH_AMP;
        run.bytes[1] = CH_G;
        run.bytes[2] = CH_T;
        run.bytes[3] = CH_SEMI;
        run.last_idx = 3'd3;
      end
      CH_QUOT: begin
        run.bytes[0] = CH_AMP;
        run.bytes[1] = CH_Q;
        run.bytes[2] = CH_U;
        run.bytes[3] = CH_O;
        run.bytes[4] = CH_T;
        run.bytes[5] = CH_SEMI;
        run.last_idx = 3'd5;
      end
      CH_APOS: begin
        if (apos_entity) begin
          run.bytes[0] = CH_AMP;
          run.bytes[1] = CH_A;
          run.bytes[2] = CH_P;
          run.bytes[3] = CH_O;
          run.bytes[4] = CH_S;
          run.bytes[5] = CH_SEMI;
          run.last_idx = 3'd5;
        end else begin
          run.bytes[0] = CH_AMP;
          run.bytes[1] = CH_HASH;
          run.bytes[2] = CH_3;
          run.bytes[3] = CH_9;
          run.bytes[4] = CH_SEMI;
          run.last_idx = 3'd4;
        end
      end
      default: begin
        if (ctrl_hex && (c < CH_SPACE || c == CH_DEL)) begin
          run.bytes[0] = CH_PCT;
          run.bytes[1] = hex_digit(c[7:4]);
          run.bytes[2] = hex_digit(c[3:0]);
          run.last_idx = 3'd2;
        end else begin
          run.bytes[0] = c;
          run.last_idx = 3'd0;
        end
      end
    endcase
  end

endmodule

### rtl/core/xte_serial.sv
// Result register and serializer: holds one escaped run and sends it one
// byte per word. Depends on xte_pkg and xte_out_if.
module xte_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  xte_pkg::xte_run_t   run,
  input  logic                fin,
  output logic                free,
  xte_out_if.source           out_ch
);
  import xte_pkg::*;

  xte_run_t             run_r;
  logic                 fin_r;
  logic                 vld_r;
  logic [RUN_IDX_W-1:0] idx_r;
  logic                 at_last;

  always_comb begin
    at_last            = (idx_r == run_r.last_idx);
    free               = !vld_r || (out_ch.ready && at_last);
    out_ch.valid       = vld_r;
    out_ch.out_byte    = run_r.bytes[idx_r];
    out_ch.last_of_run = at_last;
    out_ch.text_done   = at_last && fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (vld_r && out_ch.ready) begin
      if (at_last) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
      fin_r <= fin;
    end
  end

endmodule

### rtl/core/xml_text_escaper.sv
// Top level of the XML text escaper: configuration registers, input
// register, encoder and serializer. Depends on xte_pkg, xte_if, xte_encode
// and xte_serial.
//
// The block takes one text byte per cycle while in_ch.ready is high and
// sends its escaped form one byte per cycle while out_ch.ready is high, so a
// byte that passes unchanged gives one result byte and an escaped byte gives
// three to six; the result port, one byte per cycle, sets the sustained rate.
// An input register and a result register separate the two sides, so a new
// byte is taken while the previous run is still being sent, and a byte passes
// through the input register and then the result register to the result port.
module xml_text_escaper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xte_pkg::CFG_DATA_W-1:0]  cfg_data,
  xte_in_if.sink                          in_ch,
  xte_out_if.source                       out_ch
);
  import xte_pkg::*;

  logic              apos_entity_r;
  logic              ctrl_hex_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              final_byte_r;
  logic              in_vld_r;
  logic              ser_free;
  logic              load;
  xte_run_t          run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apos_entity_r <= 1'b0;
      ctrl_hex_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_APOS_ENTITY: apos_entity_r <= cfg_data[0];
        CFG_CTRL_HEX:    ctrl_hex_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    load        = in_vld_r && ser_free;
    in_ch.ready = !in_vld_r || ser_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r    <= in_ch.in_byte;
      final_byte_r <= in_ch.final_byte;
    end
  end

  xte_encode u_encode (
    .c           (in_byte_r),
    .apos_entity (apos_entity_r),
    .ctrl_hex    (ctrl_hex_r),
    .run         (run)
  );

  xte_serial u_serial (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .run    (run),
    .fin    (final_byte_r),
    .free   (ser_free),
    .out_ch (out_ch)
  );

endmodule

### tb/sv/xml_text_escaper_test.sv
// Self-checking testbench for xml_text_escaper: directed and random text bytes
// with random idling on both streams, checked against an in-bench predictor.
// Depends on xte_pkg, xte_if and the xml_text_escaper RTL.
module xml_text_escaper_test;
  import xte_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 26;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              text_done;
  } esc_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  xte_in_if  in_ch ();
  xte_out_if out_ch ();

  esc_word_t pending_words[$];
  logic      apos_mode;
  logic      pct_mode;
  bit        tx_idle_on;
  bit        rx_stall_on;
  int        error_count;
  int        quiet_cycles;

  xml_text_escaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end else begin
      return 8'h41 + {4'h0, nib} - 8'd10;
    end
  endfunction

  // Expands one text byte into its escaped run and queues the expected words.
  function automatic void predict_escape(input logic [BYTE_W-1:0] b, input logic fin);
    logic [RUN_MAX*BYTE_W-1:0] run;
    int                        len;
    esc_word_t                 w;
    case (b)
      CH_AMP: begin
        run = {CH_AMP, CH_A, CH_M, CH_P, CH_SEMI, 8'h00};
        len = 5;
      end
      CH_LT: begin
        run = {CH_AMP, CH_L, CH_T, CH_SEMI, 16'h0000};
        len = 4;
      end
      CH_GT: begin
        run = {CH_AMP, CH_G, CH_T, CH_SEMI, 16'h0000};
        len = 4;
      end
      CH_QUOT: begin
        run = {CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI};
        len = 6;
      end
      CH_APOS: begin
        if (apos_mode) begin
          run = {CH_AMP, CH_A, CH_P, CH_O, CH_S, CH_SEMI};
          len = 6;
        end else begin
          run = {CH_AMP, CH_HASH, CH_3, CH_9, CH_SEMI, 8'h00};
          len = 5;
        end
      end
      default: begin
        if (pct_mode && (b < CH_SPACE || b == CH_DEL)) begin
          run = {CH_PCT, hex_char(b[7:4]), hex_char(b[3:0]), 24'h000000};
          len = 3;
        end else begin
          run = {b, 40'h0};
          len = 1;
        end
      end
    endcase
    for (int k = 0; k < len; k++) begin
      w.out_byte    = run[RUN_MAX*BYTE_W-1-BYTE_W*k -: BYTE_W];
      w.last_of_run = (k == len - 1);
      w.text_done   = (k == len - 1) && fin;
      pending_words.push_back(w);
    end
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // Text bytes lean toward the characters that get escaped.
  function automatic logic [BYTE_W-1:0] text_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      case ($urandom_range(0, 4))
        0: return CH_AMP;
        1: return CH_LT;
        2: return CH_GT;
        3: return CH_QUOT;
        default: return CH_APOS;
      endcase
    end else if (pick < 5) begin
      pick = $urandom_range(0, 32);
      return (pick == 32) ? CH_DEL : BYTE_W'(pick);
    end else begin
      return BYTE_W'($urandom_range(0, 255));
    end
  endfunction

  always @(posedge clk) begin
    esc_word_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_escape(in_ch.in_byte, in_ch.final_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word: out_byte %h", out_ch.out_byte);
          error_count++;
        end else begin
          want = pending_words.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
            error_count++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, out_ch.last_of_run);
            error_count++;
          end
          if (out_ch.text_done !== want.text_done) begin
            $error("text_done: expected %b, got %b", want.text_done, out_ch.text_done);
            error_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 3) == 0) begin
          stall_left = gap_length();
        end
      end
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic fin);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_APOS_ENTITY) begin
      apos_mode = val;
    end else begin
      pct_mode = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_text(input int len);
    for (int i = 0; i < len; i++) begin
      send_word(text_byte(), (i == len - 1) ? 1'b1 : ($urandom_range(0, 19) == 0));
    end
  endtask

  task automatic test_reset_settings();
    tx_idle_on  = 1;
    rx_stall_on = 1;
    send_word(CH_AMP, 1'b0);
    send_word(CH_LT, 1'b0);
    send_word(CH_GT, 1'b0);
    send_word(CH_QUOT, 1'b0);
    send_word(CH_APOS, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h1f, 1'b0);
    send_word(CH_DEL, 1'b0);
    send_word(CH_SPACE, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(CH_A, 1'b1);
  endtask

  task automatic test_both_escapes_on();
    write_reg(CFG_APOS_ENTITY, 1'b1);
    write_reg(CFG_CTRL_HEX, 1'b1);
    send_word(CH_APOS, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h0a, 1'b0);
    send_word(8'h1f, 1'b1);
    send_word(CH_DEL, 1'b0);
    send_word(CH_SPACE, 1'b0);
    send_word(8'h7e, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(CH_QUOT, 1'b1);
    write_reg(CFG_APOS_ENTITY, 1'b0);
    send_word(CH_APOS, 1'b0);
    send_word(8'h10, 1'b1);
  endtask

  // The sender holds off after each text until every escaped word is back.
  task automatic test_pause_until_drained();
    tx_idle_on  = 1;
    rx_stall_on = 1;
    for (int t = 0; t < 4; t++) begin
      send_text($urandom_range(1, 8));
      wait_drained();
    end
  endtask

  task automatic test_random_texts();
    int sent;
    int len;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_APOS_ENTITY, phase[0]);
      write_reg(CFG_CTRL_HEX, phase[1]);
      tx_idle_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_stall_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = $urandom_range(1, 12);
        send_text(len);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_APOS_ENTITY;
    cfg_data         = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = 8'h00;
    in_ch.final_byte = 1'b0;
    apos_mode        = 1'b0;
    pct_mode         = 1'b0;
    tx_idle_on       = 0;
    rx_stall_on      = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_both_escapes_on();
    test_pause_until_drained();
    test_random_texts();

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
